/* rtl/pil_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package pil_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned POS_W   = 8;
    localparam int unsigned FUNC_W  = 2;
    localparam int unsigned STAT_W  = 2;

    // Operation codes on the input tuser
    localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DUMP   = 2'd2;

    // Result status codes on the output tuser
    localparam logic [STAT_W-1:0] STAT_STORED = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_DUMPED = 2'd2;
    localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd3;

    // Broadcast command to every cell of the chain
    typedef enum logic [1:0] {
        CMD_HOLD   = 2'd0,
        CMD_WRITE  = 2'd1,
        CMD_ROTATE = 2'd2
    } t_cell_cmd;

    typedef struct packed {
        t_cell_cmd          cmd;
        logic [VALUE_W-1:0] value;
    } t_cell_ctrl;

endpackage

`default_nettype wire

/* rtl/pil_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module pil_cell #(
    parameter int CNT_W = 6,
    parameter int IDX   = 0
) (
    input  wire logic                        i_clk,
    input  wire pil_pkg::t_cell_ctrl         i_ctrl,
    input  wire logic [CNT_W-1:0]            i_slot,
    input  wire logic [CNT_W-1:0]            i_fill,
    input  wire logic [pil_pkg::VALUE_W-1:0] i_left,
    input  wire logic [pil_pkg::VALUE_W-1:0] i_right,
    input  wire logic [pil_pkg::VALUE_W-1:0] i_head,
    output logic      [pil_pkg::VALUE_W-1:0] o_value
);
    import pil_pkg::*;

    localparam logic [CNT_W-1:0] MY_IDX   = CNT_W'(IDX);
    localparam logic [CNT_W-1:0] NEXT_IDX = CNT_W'(IDX + 1);

    logic [VALUE_W-1:0] r_value;
    logic [VALUE_W-1:0] n_value;

    always_comb begin
        n_value = r_value;
        case (i_ctrl.cmd)
            CMD_WRITE: begin
                // New item lands at the slot, the tail beyond it moves up one
                if (MY_IDX == i_slot) begin
                    n_value = i_ctrl.value;
                end else if (MY_IDX > i_slot && MY_IDX <= i_fill) begin
                    n_value = i_left;
                end
            end
            CMD_ROTATE: begin
                // Advance toward the head, last element takes the old head
                if (NEXT_IDX < i_fill) begin
                    n_value = i_right;
                end else if (NEXT_IDX == i_fill) begin
                    n_value = i_head;
                end
            end
            default: n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

`default_nettype wire

/* rtl/positional_insert_list_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  tdata (low bit up)                     tuser        tlast
// s_axis    in   item_value[31:0], position[39:32]      func[1:0]    -
// m_axis    out  out_value[31:0]                        status[1:0]  final result of item
//
// Append and insert complete on acceptance: the chain shifts its tail as the item is
// accepted and the result is loaded into the output register.
// A dump rotates the chain through cell 0, one element a cycle while the output is
// not stalled, and the list of N elements is back in order after N rotations.
// Reset (synchronous, active low) clears the fill count, state and output valid flag.
// A stalled output holds its result, blocks new items and pauses a dump.

module positional_insert_list_core #(
    parameter int CAPACITY = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // item_value[31:0], position[39:32]
    input  wire logic [39:0]                 i_s_axis_tdata,
    // func[1:0]
    input  wire logic [pil_pkg::FUNC_W-1:0]  i_s_axis_tuser,
    output logic                             o_m_axis_tvalid,
    input  wire logic                        i_m_axis_tready,
    // out_value[31:0]
    output logic      [31:0]                 o_m_axis_tdata,
    // status[1:0]
    output logic      [pil_pkg::STAT_W-1:0]  o_m_axis_tuser,
    output logic                             o_m_axis_tlast
);
    import pil_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
    localparam int CMP_W = (CNT_W > POS_W ? CNT_W : POS_W) + 1;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_DUMP = 2'b10
    } t_state;

    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_fill, n_fill;
    logic [CNT_W-1:0]     r_dump_idx, n_dump_idx;
    logic                 r_out_valid, n_out_valid;
    logic [STAT_W-1:0]    r_out_status, n_out_status;
    logic [VALUE_W-1:0]   r_out_value, n_out_value;
    logic                 r_out_last, n_out_last;

    logic [VALUE_W-1:0]   in_value;
    logic [POS_W-1:0]     in_pos;
    logic                 out_free;
    logic                 in_accept;
    logic                 dump_last;
    logic [CMP_W-1:0]     pos_plus1;
    logic                 do_append;
    logic [CNT_W-1:0]     slot;
    t_cell_ctrl           cell_ctrl;
    logic [VALUE_W-1:0]   cell_val [CAPACITY];

    assign in_value  = i_s_axis_tdata[31:0];
    assign in_pos    = i_s_axis_tdata[39:32];
    assign out_free  = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == ST_IDLE) && out_free;
    assign in_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign dump_last = (r_dump_idx + CNT_W'(1)) == r_fill;

    // Insert after position: a position at or past the last element appends
    assign pos_plus1 = CMP_W'(in_pos) + CMP_W'(1);
    assign do_append = (i_s_axis_tuser == FUNC_APPEND) || (r_fill == '0)
                       || (pos_plus1 >= CMP_W'(r_fill));
    assign slot      = do_append ? r_fill : pos_plus1[CNT_W-1:0];

    always_comb begin
        n_state      = r_state;
        n_fill       = r_fill;
        n_dump_idx   = r_dump_idx;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out_status = r_out_status;
        n_out_value  = r_out_value;
        n_out_last   = r_out_last;
        cell_ctrl.cmd   = CMD_HOLD;
        cell_ctrl.value = in_value;

        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    if (i_s_axis_tuser[1]) begin
                        // Dump; the unused code decodes the same way
                        if (r_fill == '0) begin
                            n_out_valid  = 1'b1;
                            n_out_status = STAT_EMPTY;
                            n_out_value  = '0;
                            n_out_last   = 1'b1;
                        end else begin
                            n_state    = ST_DUMP;
                            n_dump_idx = '0;
                        end
                    end else if (r_fill == CAP_CNT) begin
                        // Drop the write and flag it
                        n_out_valid  = 1'b1;
                        n_out_status = STAT_FULL;
                        n_out_value  = '0;
                        n_out_last   = 1'b1;
                    end else begin
                        cell_ctrl.cmd = CMD_WRITE;
                        n_fill        = r_fill + CNT_W'(1);
                        n_out_valid   = 1'b1;
                        n_out_status  = STAT_STORED;
                        n_out_value   = '0;
                        n_out_last    = 1'b1;
                    end
                end
            end
            ST_DUMP: begin
                if (out_free) begin
                    // Emit the head and rotate the chain by one
                    cell_ctrl.cmd = CMD_ROTATE;
                    n_out_valid   = 1'b1;
                    n_out_status  = STAT_DUMPED;
                    n_out_value   = cell_val[0];
                    n_out_last    = dump_last;
                    n_dump_idx    = r_dump_idx + CNT_W'(1);
                    if (dump_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_dump_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_dump_idx  <= n_dump_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_status <= n_out_status;
        r_out_value  <= n_out_value;
        r_out_last   <= n_out_last;
    end

    // Chain of cells: each takes from its left on an insert, from its right on
    // a rotate, and the cell at the tail takes the head value on a rotate
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [VALUE_W-1:0] left_val;
        logic [VALUE_W-1:0] right_val;

        if (g == 0) begin : g_first
            assign left_val = cell_val[g];
        end else begin : g_mid_l
            assign left_val = cell_val[g-1];
        end

        if (g == CAPACITY - 1) begin : g_final
            assign right_val = cell_val[g];
        end else begin : g_mid_r
            assign right_val = cell_val[g+1];
        end

        pil_cell #(
            .CNT_W (CNT_W),
            .IDX   (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (cell_ctrl),
            .i_slot  (slot),
            .i_fill  (r_fill),
            .i_left  (left_val),
            .i_right (right_val),
            .i_head  (cell_val[0]),
            .o_value (cell_val[g])
        );
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_value;
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

/* rtl/pil_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module pil_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_s_axis_tvalid,
    input wire logic                        o_s_axis_tready,
    input wire logic [39:0]                 i_s_axis_tdata,
    input wire logic [pil_pkg::FUNC_W-1:0]  i_s_axis_tuser,
    input wire logic                        o_m_axis_tvalid,
    input wire logic                        i_m_axis_tready,
    input wire logic [31:0]                 o_m_axis_tdata,
    input wire logic [pil_pkg::STAT_W-1:0]  o_m_axis_tuser,
    input wire logic                        o_m_axis_tlast
);
    import pil_pkg::*;

    // A result waiting to be taken stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result withdrawn while stalled");

    // No new item is taken in the middle of a dump
    a_no_accept_in_dump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tlast |-> !o_s_axis_tready)
        else $error("input ready during a dump");

    // Non-dump results are single, final and carry zero data
    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser != STAT_DUMPED
        |-> o_m_axis_tlast && o_m_axis_tdata == '0)
        else $error("status result malformed");

    // A write item is answered in the next cycle
    a_write_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && !i_s_axis_tuser[1]
        |=> o_m_axis_tvalid && o_m_axis_tlast
            && (o_m_axis_tuser == STAT_STORED || o_m_axis_tuser == STAT_FULL))
        else $error("write item not answered");

endmodule

bind positional_insert_list_core pil_checker u_pil_checker (.*);

`default_nettype wire
